// ----- rtl/assert_macros.svh -----
// Assertion helpers for the pixel blend block.
// Depends on clk and rst_n being visible at the place of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_NOW(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- rtl/dtpb_pkg.sv -----
// Package for the depth tested pixel blend block: codes, states, defaults.
// No dependencies.
package dtpb_pkg;

    // Default geometry and depth precision
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_DEPTH_BITS = 24;

    // Configuration register file
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DIM_W      = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLEAR_COLOR  = 2'd2;

    localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 9'd256;
    localparam logic [31:0]      RST_CLEAR_COLOR  = 32'd0;

    // Operation codes
    typedef enum logic [2:0] {
        OP_OPAQUE     = 3'd0,
        OP_ALPHA      = 3'd1,
        OP_READ_COLOR = 3'd2,
        OP_READ_DEPTH = 3'd3,
        OP_CLEAR      = 3'd4
    } dtpb_op_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_MUL,
        ST_READ,
        ST_CALC,
        ST_DONE
    } dtpb_state_t;

endpackage

// ----- rtl/dtpb_if.sv -----
// Channel interfaces for the pixel blend block: fragment in, result out, config.
// Depends on dtpb_pkg.
interface dtpb_in_if
    import dtpb_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic signed [15:0] x_pos;
    logic signed [15:0] y_pos;
    logic [7:0]         src_red;
    logic [7:0]         src_green;
    logic [7:0]         src_blue;
    logic [7:0]         src_alpha;
    logic [23:0]        src_depth;

    modport source (output valid, opcode, x_pos, y_pos, src_red, src_green, src_blue,
                    src_alpha, src_depth, input ready);
    modport sink (input valid, opcode, x_pos, y_pos, src_red, src_green, src_blue,
                  src_alpha, src_depth, output ready);
endinterface

interface dtpb_out_if
    import dtpb_pkg::*;
();
    logic        valid;
    logic        ready;
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [7:0]  out_alpha;
    logic [23:0] out_depth;
    logic        in_bounds;
    logic        write_done;

    modport source (output valid, out_red, out_green, out_blue, out_alpha, out_depth,
                    in_bounds, write_done, input ready);
    modport sink (input valid, out_red, out_green, out_blue, out_alpha, out_depth,
                  in_bounds, write_done, output ready);
endinterface

interface dtpb_cfg_if
    import dtpb_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/dtpb_blend.sv -----
// Alpha blend unit: registered per-channel weighted sums, then divide by 255.
// Depends on dtpb_pkg.
module dtpb_blend
    import dtpb_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  logic [31:0] src_color,
    input  logic [31:0] dst_color,
    output logic [31:0] mix_color
);

    logic [15:0] sum_reg [4];
    logic [15:0] sum_next [4];
    logic [7:0]  alpha;
    logic [7:0]  alpha_inv;

    // floor(n / 255) for n below 65280
    function automatic logic [7:0] div255(input logic [15:0] n);
        logic [16:0] t;
        t = 17'(n) + 17'(n >> 8) + 17'd1;
        return t[15:8];
    endfunction

    assign alpha     = src_color[7:0];
    assign alpha_inv = 8'd255 - alpha;

    // Weighted sums; alpha lane blends against full coverage
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            logic [7:0] s;
            logic [7:0] d;
            s = (i == 0) ? 8'hFF : src_color[8*i +: 8];
            d = dst_color[8*i +: 8];
            sum_next[i] = 16'(s) * 16'(alpha) + 16'(d) * 16'(alpha_inv);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg <= sum_next;
        end
    end

    // Divide stage
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            mix_color[8*i +: 8] = div255(sum_reg[i]);
        end
    end

endmodule

// ----- rtl/depth_tested_pixel_blend.sv -----
// Raster output unit: depth tested write, alpha blend, read back, clear.
// Depends on dtpb_pkg, dtpb_if, dtpb_blend and assert_macros.svh.
//
//  channel   dir   handshake         payload
//  pix_in    in    valid / ready     opcode, x_pos, y_pos, src rgba, src_depth
//  pix_out   out   valid / ready     out rgba, out_depth, in_bounds, write_done
//  cfg       in    valid / ready     index, data (ready always high)
//
// An item passes through accept, row multiply, memory read, test and blend
// products, and write back. One item is in flight; the memory read latency and
// the read-modify-write of one entry keep it so.
// After reset, and for each clear, a sweep writes all MAX_WIDTH*MAX_HEIGHT
// entries (65536 by default), one per cycle, with pix_in held off.
// The result register lets a new item enter while the last result waits.
`include "assert_macros.svh"

module depth_tested_pixel_blend
    import dtpb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int DEPTH_BITS = DEF_DEPTH_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    dtpb_in_if.sink     pix_in,
    dtpb_out_if.source  pix_out,
    dtpb_cfg_if.sink    cfg
);

    localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int XI_W       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YI_W       = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WD_W       = $clog2(MAX_WIDTH + 1);
    localparam int HT_W       = $clog2(MAX_HEIGHT + 1);
    localparam int PROD_W     = YI_W + WD_W;
    localparam int CMP_W      = (DEPTH_BITS > 24) ? DEPTH_BITS : 24;

    localparam logic [DEPTH_BITS-1:0] DEPTH_FAR  = {DEPTH_BITS{1'b1}};
    localparam logic [ADDR_W-1:0]     LAST_ADDR  = ADDR_W'(STORE_SIZE - 1);

    // Configuration registers
    logic [DIM_W-1:0] frame_width_reg;
    logic [DIM_W-1:0] frame_height_reg;
    logic [31:0]      clear_color_reg;

    // Sequencer
    dtpb_state_t state_reg, state_next;
    logic [ADDR_W-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic              clear_pending_reg, clear_pending_next;
    logic [31:0]       fill_color_reg, fill_color_next;

    // Item registers
    logic [2:0]            op_reg;
    logic                  inb_reg;
    logic [XI_W-1:0]       x_idx_reg;
    logic [YI_W-1:0]       y_idx_reg;
    logic [31:0]           src_color_reg;
    logic [DEPTH_BITS-1:0] src_depth_reg;
    logic [PROD_W-1:0]     prod_reg;
    logic [ADDR_W-1:0]     addr_reg;
    logic                  pass_reg;

    // Memories and read data
    logic [31:0]           color_mem [STORE_SIZE];
    logic [DEPTH_BITS-1:0] depth_mem [STORE_SIZE];
    logic [31:0]           color_rd_reg;
    logic [DEPTH_BITS-1:0] depth_rd_reg;

    // Result register
    logic        out_valid_reg;
    logic [31:0] out_color_reg;
    logic [23:0] out_depth_reg;
    logic        out_inb_reg;
    logic        out_done_reg;

    // Combinational helpers
    logic [WD_W-1:0]       width_sat;
    logic [HT_W-1:0]       height_sat;
    logic                  in_hs;
    logic                  in_bounds_now;
    logic [CMP_W-1:0]      src_depth_ext;
    logic [DEPTH_BITS-1:0] src_depth_sat;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  rd_en;
    logic                  slot_free;
    logic                  load_out;
    logic                  pass_next;
    logic [31:0]           mix_color;
    logic [31:0]           new_color;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [31:0]           mem_wcolor;
    logic [DEPTH_BITS-1:0] mem_wdepth;
    logic [31:0]           res_color;
    logic [23:0]           res_depth;

    // Config port, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            clear_color_reg  <= RST_CLEAR_COLOR;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg.data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg.data[DIM_W-1:0];
                CFG_CLEAR_COLOR:  clear_color_reg  <= cfg.data;
                default:          ;
            endcase
        end
    end

    // Saturated surface size
    assign width_sat  = ({7'd0, frame_width_reg} > 16'(MAX_WIDTH))
                      ? WD_W'(MAX_WIDTH) : WD_W'(frame_width_reg);
    assign height_sat = ({7'd0, frame_height_reg} > 16'(MAX_HEIGHT))
                      ? HT_W'(MAX_HEIGHT) : HT_W'(frame_height_reg);

    // Bounds check on the incoming position
    assign in_bounds_now = !pix_in.x_pos[15] && !pix_in.y_pos[15]
                        && ($unsigned(pix_in.x_pos) < 16'(width_sat))
                        && ($unsigned(pix_in.y_pos) < 16'(height_sat));

    // Depth clamp to the stored precision
    assign src_depth_ext = CMP_W'(pix_in.src_depth);
    assign src_depth_sat = (src_depth_ext > CMP_W'(DEPTH_FAR))
                         ? DEPTH_FAR : DEPTH_BITS'(src_depth_ext);

    assign pix_in.ready = (state_reg == ST_IDLE);
    assign in_hs        = pix_in.valid && pix_in.ready;

    // Address: row base plus column
    assign rd_addr = ADDR_W'((PROD_W + 1)'(prod_reg) + (PROD_W + 1)'(x_idx_reg));
    assign rd_en   = (state_reg == ST_READ);

    // Depth test; equal depth passes
    assign pass_next = inb_reg && ((op_reg == OP_OPAQUE) || (op_reg == OP_ALPHA))
                    && (CMP_W'(src_depth_reg) <= CMP_W'(depth_rd_reg));

    dtpb_blend u_blend (
        .clk       (clk),
        .load      (state_reg == ST_CALC),
        .src_color (src_color_reg),
        .dst_color (color_rd_reg),
        .mix_color (mix_color)
    );

    assign new_color = (op_reg == OP_OPAQUE) ? src_color_reg : mix_color;
    assign slot_free = !out_valid_reg || pix_out.ready;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_SWEEP;
            sweep_cnt_reg     <= '0;
            clear_pending_reg <= 1'b0;
            fill_color_reg    <= RST_CLEAR_COLOR;
        end
        else
        begin
            state_reg         <= state_next;
            sweep_cnt_reg     <= sweep_cnt_next;
            clear_pending_reg <= clear_pending_next;
            fill_color_reg    <= fill_color_next;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        sweep_cnt_next     = sweep_cnt_reg;
        clear_pending_next = clear_pending_reg;
        fill_color_next    = fill_color_reg;
        load_out           = 1'b0;
        mem_we             = 1'b0;
        mem_waddr          = addr_reg;
        mem_wcolor         = new_color;
        mem_wdepth         = src_depth_reg;
        case (state_reg)
            ST_SWEEP:
            begin
                mem_we     = 1'b1;
                mem_waddr  = sweep_cnt_reg;
                mem_wcolor = fill_color_reg;
                mem_wdepth = DEPTH_FAR;
                if (sweep_cnt_reg == LAST_ADDR)
                begin
                    sweep_cnt_next     = '0;
                    clear_pending_next = 1'b0;
                    state_next         = clear_pending_reg ? ST_DONE : ST_IDLE;
                end
                else
                begin
                    sweep_cnt_next = sweep_cnt_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (in_hs)
                begin
                    if (pix_in.opcode == OP_CLEAR)
                    begin
                        state_next         = ST_SWEEP;
                        clear_pending_next = 1'b1;
                        fill_color_next    = clear_color_reg;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:  state_next = ST_READ;
            ST_READ: state_next = ST_CALC;
            ST_CALC: state_next = ST_DONE;
            ST_DONE:
            begin
                if (slot_free)
                begin
                    load_out   = 1'b1;
                    mem_we     = pass_reg;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Item capture and per-stage registers
    always_ff @(posedge clk)
    begin
        if (in_hs)
        begin
            op_reg        <= pix_in.opcode;
            inb_reg       <= in_bounds_now;
            x_idx_reg     <= XI_W'($unsigned(pix_in.x_pos));
            y_idx_reg     <= YI_W'($unsigned(pix_in.y_pos));
            src_color_reg <= {pix_in.src_red, pix_in.src_green,
                              pix_in.src_blue, pix_in.src_alpha};
            src_depth_reg <= src_depth_sat;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= PROD_W'(y_idx_reg) * PROD_W'(width_sat);
        end
        if (rd_en)
        begin
            addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pass_reg <= 1'b0;
        end
        else if (in_hs)
        begin
            pass_reg <= 1'b0;
        end
        else if (state_reg == ST_CALC)
        begin
            pass_reg <= pass_next;
        end
    end

    // Color and depth memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            color_mem[mem_waddr] <= mem_wcolor;
            depth_mem[mem_waddr] <= mem_wdepth;
        end
        if (rd_en)
        begin
            color_rd_reg <= color_mem[rd_addr];
            depth_rd_reg <= depth_mem[rd_addr];
        end
    end

    // Result selection
    always_comb
    begin
        if (op_reg == OP_CLEAR)
        begin
            res_color = fill_color_reg;
            res_depth = 24'(CMP_W'(DEPTH_FAR));
        end
        else if (!inb_reg)
        begin
            res_color = '0;
            res_depth = '1;
        end
        else if (pass_reg)
        begin
            res_color = new_color;
            res_depth = 24'(CMP_W'(src_depth_reg));
        end
        else
        begin
            res_color = color_rd_reg;
            res_depth = 24'(CMP_W'(depth_rd_reg));
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_color_reg <= res_color;
            out_depth_reg <= res_depth;
            out_inb_reg   <= inb_reg;
            out_done_reg  <= pass_reg;
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.out_red    = out_color_reg[31:24];
    assign pix_out.out_green  = out_color_reg[23:16];
    assign pix_out.out_blue   = out_color_reg[15:8];
    assign pix_out.out_alpha  = out_color_reg[7:0];
    assign pix_out.out_depth  = out_depth_reg;
    assign pix_out.in_bounds  = out_inb_reg;
    assign pix_out.write_done = out_done_reg;

    // Checks
    `ASSERT_NOW(a_we_state, mem_we, (state_reg == ST_SWEEP) || (state_reg == ST_DONE), "memory write outside sweep or write back")
    `ASSERT_NOW(a_done_inb, pix_out.valid && pix_out.write_done, pix_out.in_bounds, "write reported for out of bounds position")
    `ASSERT_NEXT(a_clear_sweep, in_hs && (pix_in.opcode == OP_CLEAR), (state_reg == ST_SWEEP) && (sweep_cnt_reg == '0), "clear did not start a sweep")
    `ASSERT_NEXT(a_sweep_end, (state_reg == ST_SWEEP) && (sweep_cnt_reg == LAST_ADDR), (state_reg == ST_IDLE) || (state_reg == ST_DONE), "sweep did not finish at last entry")

endmodule

// ----- tb/dtpb_pixel_compare.sv -----
// Result checker for depth_tested_pixel_blend: follows the frame registers, keeps its own
// colour and depth stores, predicts each result transaction and compares it on arrival.
// Depends on dtpb_pkg and the channel interfaces in dtpb_if.sv.
`timescale 1ns / 100ps

module dtpb_pixel_compare
    import dtpb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    dtpb_in_if   pix_in,
    dtpb_out_if  pix_out,
    dtpb_cfg_if  cfg,
    output int   fail_count,
    output int   outstanding,
    output int   results_seen
);

    localparam int STORE_ENTRIES = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
    localparam logic [DEF_DEPTH_BITS-1:0] DEPTH_FAR = '1;
    localparam int CHAN_MAX    = 255;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [23:0] depth;
        logic        in_bounds;
        logic        write_done;
    } pixel_result_t;

    // Frame registers as last written
    logic [DIM_W-1:0] frame_w;
    logic [DIM_W-1:0] frame_h;
    logic [31:0]      clear_rgba;

    // Sparse stores: an entry never written since the last clear holds the fill values
    logic [31:0]               fill_rgba;
    logic [31:0]               color_mem [int];
    logic [DEF_DEPTH_BITS-1:0] depth_mem [int];

    pixel_result_t pending_pixels [$];

    function automatic logic [31:0] color_at(input int addr);
        if (color_mem.exists(addr))
            return color_mem[addr];
        return fill_rgba;
    endfunction

    function automatic logic [DEF_DEPTH_BITS-1:0] depth_at(input int addr);
        if (depth_mem.exists(addr))
            return depth_mem[addr];
        return DEPTH_FAR;
    endfunction

    // floor((s*a + d*(255-a)) / 255)
    function automatic logic [7:0] blend_channel(input logic [7:0] s, input logic [7:0] d,
                                                 input logic [7:0] a);
        int mixed;
        mixed = (int'(s) * int'(a) + int'(d) * (CHAN_MAX - int'(a))) / CHAN_MAX;
        return mixed[7:0];
    endfunction

    // Applies one fragment to the stores and returns the result it should produce
    function automatic pixel_result_t render_fragment(
        input logic [2:0]               op,
        input logic signed [15:0]       x,
        input logic signed [15:0]       y,
        input logic [31:0]              src_rgba,
        input logic [DEF_DEPTH_BITS-1:0] src_z
    );
        pixel_result_t res;
        int            w;
        int            h;
        int            xi;
        int            yi;
        int            addr;
        logic          hit;
        logic [31:0]   dst;
        logic [31:0]   rgba;
        logic [7:0]    a;

        w    = (frame_w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(frame_w);
        h    = (frame_h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(frame_h);
        xi   = x;
        yi   = y;
        hit  = (xi >= 0) && (yi >= 0) && (xi < w) && (yi < h);
        addr = hit ? (yi * w + xi) % STORE_ENTRIES : 0;
        a    = src_rgba[7:0];
        rgba = '0;
        res  = '0;
        res.in_bounds = hit;
        res.depth     = DEPTH_FAR;

        if (op == OP_CLEAR) begin
            color_mem.delete();
            depth_mem.delete();
            fill_rgba = clear_rgba;
            rgba      = clear_rgba;
        end else begin
            // Depth test: equal depth passes
            if (hit && (op == OP_OPAQUE || op == OP_ALPHA) && src_z <= depth_at(addr)) begin
                depth_mem[addr] = src_z;
                if (op == OP_OPAQUE) begin
                    color_mem[addr] = src_rgba;
                end else begin
                    dst = color_at(addr);
                    color_mem[addr] = {blend_channel(src_rgba[31:24], dst[31:24], a),
                                       blend_channel(src_rgba[23:16], dst[23:16], a),
                                       blend_channel(src_rgba[15:8], dst[15:8], a),
                                       blend_channel(8'(CHAN_MAX), dst[7:0], a)};
                end
                res.write_done = 1'b1;
            end
            if (hit) begin
                rgba      = color_at(addr);
                res.depth = depth_at(addr);
            end
        end

        {res.red, res.green, res.blue, res.alpha} = rgba;
        return res;
    endfunction

    // Watch all three channels; results are checked before new fragments are queued
    always @(posedge clk or negedge rst_n) begin : watch
        pixel_result_t got;
        pixel_result_t want;

        if (!rst_n) begin
            frame_w    = RST_FRAME_WIDTH;
            frame_h    = RST_FRAME_HEIGHT;
            clear_rgba = RST_CLEAR_COLOR;
            fill_rgba  = '0;
            color_mem.delete();
            depth_mem.delete();
            pending_pixels.delete();
            outstanding = 0;
        end else begin
            if (pix_out.valid && pix_out.ready) begin
                results_seen++;
                got.red        = pix_out.out_red;
                got.green      = pix_out.out_green;
                got.blue       = pix_out.out_blue;
                got.alpha      = pix_out.out_alpha;
                got.depth      = pix_out.out_depth;
                got.in_bounds  = pix_out.in_bounds;
                got.write_done = pix_out.write_done;
                if (pending_pixels.size() == 0) begin
                    if (fail_count < MAX_REPORTS)
                        $display("result %0d arrived with no fragment pending: rgba %h depth %h",
                                 results_seen, {got.red, got.green, got.blue, got.alpha},
                                 got.depth);
                    fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue || got.alpha !== want.alpha ||
                        got.depth !== want.depth || got.in_bounds !== want.in_bounds ||
                        got.write_done !== want.write_done) begin
                        if (fail_count < MAX_REPORTS)
                            $display({"result %0d mismatch: expected rgba %h depth %h inb %b ",
                                      "done %b, got rgba %h depth %h inb %b done %b"},
                                     results_seen,
                                     {want.red, want.green, want.blue, want.alpha},
                                     want.depth, want.in_bounds, want.write_done,
                                     {got.red, got.green, got.blue, got.alpha},
                                     got.depth, got.in_bounds, got.write_done);
                        fail_count++;
                    end
                end
            end

            // Register writes
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    CFG_FRAME_WIDTH:  frame_w = cfg.data[DIM_W-1:0];
                    CFG_FRAME_HEIGHT: frame_h = cfg.data[DIM_W-1:0];
                    CFG_CLEAR_COLOR:  clear_rgba = cfg.data;
                    default: ;
                endcase
            end

            // Accepted fragment
            if (pix_in.valid && pix_in.ready)
                pending_pixels.push_back(render_fragment(
                    pix_in.opcode, pix_in.x_pos, pix_in.y_pos,
                    {pix_in.src_red, pix_in.src_green, pix_in.src_blue, pix_in.src_alpha},
                    pix_in.src_depth));

            outstanding = pending_pixels.size();
        end
    end

endmodule

// ----- tb/depth_tested_pixel_blend_test.sv -----
// Top of the depth_tested_pixel_blend testbench: clock, reset, fragment and register
// stimulus, result back-pressure and the verdict. Depends on dtpb_pkg, dtpb_if.sv,
// the block itself and dtpb_pixel_compare.
`timescale 1ns / 100ps

module depth_tested_pixel_blend_test;
    import dtpb_pkg::*;

    localparam int LIMIT_CYCLES     = 3_000_000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 120;
    localparam int LONG_HOLD_AFTER  = 400;
    localparam int RANDOM_CLEARS    = 5;
    localparam int NUM_PHASES       = 9;

    // Opcodes the block does not define; they report like a read
    localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

    // Frame settings per random phase; width/height 0 and the saturating values included
    localparam int PHASE_W [NUM_PHASES]     = '{1, 4, 0, 511, 8, 256, 12, 257, 16};
    localparam int PHASE_H [NUM_PHASES]     = '{1, 4, 256, 300, 3, 256, 0, 511, 16};
    localparam int PHASE_ITEMS [NUM_PHASES] = '{244, 244, 60, 244, 244, 244, 60, 244, 244};

    typedef struct {
        logic [2:0]         op;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [31:0]        rgba;
        logic [23:0]        z;
    } fragment_t;

    logic        clk;
    logic        rst_n;
    int          fail_count;
    int          outstanding;
    int          results_seen;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          cycle_count;
    int          hold_left;
    bit          long_hold_done;
    int          clears_left;
    logic [23:0] depth_front;

    dtpb_in_if  pix_in_if ();
    dtpb_out_if pix_out_if ();
    dtpb_cfg_if cfg_if ();

    depth_tested_pixel_blend u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pix_in  (pix_in_if),
        .pix_out (pix_out_if),
        .cfg     (cfg_if)
    );

    dtpb_pixel_compare u_compare (
        .clk          (clk),
        .rst_n        (rst_n),
        .pix_in       (pix_in_if),
        .pix_out      (pix_out_if),
        .cfg          (cfg_if),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .results_seen (results_seen)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Run limit
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Result back-pressure: random stall bursts plus one long hold that fills the block
    initial
    begin : result_sink
        pix_out_if.ready = 1'b0;
        hold_left        = 0;
        long_hold_done   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                pix_out_if.ready <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD_CYCLES - 1;
                pix_out_if.ready <= 1'b0;
            end
            else if (sink_stall_pct > 0 && $urandom_range(0, 99) < sink_stall_pct)
            begin
                hold_left = $urandom_range(0, 12);
                pix_out_if.ready <= 1'b0;
            end
            else
            begin
                pix_out_if.ready <= 1'b1;
            end
        end
    end

    function automatic fragment_t mk_frag(input logic [2:0] op, input int x, input int y,
                                          input logic [31:0] rgba, input logic [23:0] z);
        fragment_t f;
        f.op   = op;
        f.x    = 16'(x);
        f.y    = 16'(y);
        f.rgba = rgba;
        f.z    = z;
        return f;
    endfunction

    // One fragment transaction, with an optional idle burst in front; leaves valid high
    task automatic drive_fragment(input fragment_t f);
        if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            pix_in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        pix_in_if.valid     <= 1'b1;
        pix_in_if.opcode    <= f.op;
        pix_in_if.x_pos     <= f.x;
        pix_in_if.y_pos     <= f.y;
        pix_in_if.src_red   <= f.rgba[31:24];
        pix_in_if.src_green <= f.rgba[23:16];
        pix_in_if.src_blue  <= f.rgba[15:8];
        pix_in_if.src_alpha <= f.rgba[7:0];
        pix_in_if.src_depth <= f.z;
        do
            @(posedge clk);
        while (!pix_in_if.ready);
        @(negedge clk);
    endtask

    // Stop sending and wait until every predicted result has been taken
    task automatic drain_results();
        pix_in_if.valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write all three frame registers back to back; only called with the block idle
    task automatic load_frame_regs(input int w, input int h, input logic [31:0] color);
        logic [CFG_IDX_W-1:0]  idx [3];
        logic [CFG_DATA_W-1:0] val [3];
        idx = '{CFG_FRAME_WIDTH, CFG_FRAME_HEIGHT, CFG_CLEAR_COLOR};
        val = '{32'(w), 32'(h), color};
        for (int i = 0; i < 3; i++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[i];
            cfg_if.data  <= val[i];
            do
                @(posedge clk);
            while (!cfg_if.ready);
            @(negedge clk);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly in-bounds writes with depths close to a falling front, so that passes,
    // ties and rejections all occur; the rest is out-of-range noise
    function automatic fragment_t random_fragment(input int eff_w, input int eff_h,
                                                  input bit last_one);
        fragment_t f;
        int        pick;

        pick = $urandom_range(0, 99);
        if (clears_left > 0 && !last_one && $urandom_range(0, 249) == 0)
        begin
            f.op = OP_CLEAR;
            clears_left--;
        end
        else if (pick < 35)
            f.op = OP_OPAQUE;
        else if (pick < 65)
            f.op = OP_ALPHA;
        else if (pick < 78)
            f.op = OP_READ_COLOR;
        else if (pick < 92)
            f.op = OP_READ_DEPTH;
        else
            f.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));

        if (eff_w > 0 && eff_h > 0 && $urandom_range(0, 99) < 85)
        begin
            f.x = 16'($urandom_range(0, eff_w - 1));
            f.y = 16'($urandom_range(0, eff_h - 1));
        end
        else
        begin
            case ($urandom_range(0, 3))
                0:
                begin
                    f.x = 16'($urandom);
                    f.y = 16'($urandom);
                end
                1:
                begin
                    f.x = 16'(eff_w + $urandom_range(0, 3));
                    f.y = 16'($urandom_range(0, 255));
                end
                2:
                begin
                    f.x = 16'($urandom_range(0, 255));
                    f.y = 16'(-int'($urandom_range(1, 4)));
                end
                default:
                begin
                    f.x = 16'(-int'($urandom_range(1, 4)));
                    f.y = 16'(eff_h + $urandom_range(0, 3));
                end
            endcase
        end

        pick = $urandom_range(0, 99);
        if (pick < 2)
            f.z = '0;
        else if (pick < 8)
            f.z = '1;
        else if (pick < 25)
            f.z = 24'($urandom);
        else
            f.z = depth_front + 24'($urandom_range(0, 24));
        depth_front = depth_front - 24'd1;

        f.rgba = $urandom;
        case ($urandom_range(0, 3))
            0: f.rgba[7:0] = 8'h00;
            1: f.rgba[7:0] = 8'hFF;
            default: ;
        endcase
        return f;
    endfunction

    // Reset, directed fragments, then one random phase per frame setting
    initial
    begin : stimulus
        fragment_t   directed [$];
        int          eff_w;
        int          eff_h;
        logic [31:0] clr;

        rst_n                = 1'b0;
        pix_in_if.valid      = 1'b0;
        pix_in_if.opcode     = OP_OPAQUE;
        pix_in_if.x_pos      = '0;
        pix_in_if.y_pos      = '0;
        pix_in_if.src_red    = '0;
        pix_in_if.src_green  = '0;
        pix_in_if.src_blue   = '0;
        pix_in_if.src_alpha  = '0;
        pix_in_if.src_depth  = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = CFG_FRAME_WIDTH;
        cfg_if.data          = '0;
        src_idle_pct         = 0;
        sink_stall_pct       = 0;
        clears_left          = RANDOM_CLEARS;
        depth_front          = 24'hC00000;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part on the reset frame (256 x 256, clear colour zero)
        directed.push_back(mk_frag(OP_OPAQUE, 0, 0, 32'hFFFFFFFF, 24'h800000));
        directed.push_back(mk_frag(OP_READ_COLOR, 0, 0, 32'h0, 24'h0));
        directed.push_back(mk_frag(OP_READ_DEPTH, 0, 0, 32'h0, 24'h0));
        // farther than stored: rejected
        directed.push_back(mk_frag(OP_OPAQUE, 0, 0, 32'h12345678, 24'h800001));
        // same depth: passes
        directed.push_back(mk_frag(OP_OPAQUE, 0, 0, 32'h00000000, 24'h800000));
        // half, zero and full alpha blends
        directed.push_back(mk_frag(OP_ALPHA, 0, 0, 32'hFFFFFF80, 24'h7FFFFF));
        directed.push_back(mk_frag(OP_ALPHA, 0, 0, 32'hA5A5A500, 24'h7FFFFF));
        directed.push_back(mk_frag(OP_ALPHA, 0, 0, 32'h00FF00FF, 24'h000000));
        // far corner at the farthest depth
        directed.push_back(mk_frag(OP_OPAQUE, 255, 255, 32'hAA55AA55, 24'hFFFFFF));
        directed.push_back(mk_frag(OP_READ_DEPTH, 255, 255, 32'h0, 24'h0));
        // out of bounds on every side
        directed.push_back(mk_frag(OP_OPAQUE, 256, 0, 32'h11223344, 24'h0));
        directed.push_back(mk_frag(OP_OPAQUE, 0, 256, 32'h55667788, 24'h0));
        directed.push_back(mk_frag(OP_ALPHA, -1, 0, 32'h99AABBCC, 24'h0));
        directed.push_back(mk_frag(OP_READ_COLOR, 32767, -32768, 32'h0, 24'h0));
        directed.push_back(mk_frag(OP_READ_DEPTH, -32768, 32767, 32'h0, 24'h0));
        // undefined opcodes
        directed.push_back(mk_frag(OP_SPARE_FIRST, 0, 0, 32'hFFFFFFFF, 24'h0));
        directed.push_back(mk_frag(OP_SPARE_FIRST + 1, 255, 255, 32'hFFFFFFFF, 24'h0));
        directed.push_back(mk_frag(OP_SPARE_LAST, -1, -1, 32'hFFFFFFFF, 24'h0));
        // blend into a never written pixel
        directed.push_back(mk_frag(OP_ALPHA, 1, 0, 32'hFFFFFF40, 24'h0));
        // clear from an out-of-range position, then read back
        directed.push_back(mk_frag(OP_CLEAR, -5, 3, 32'h0, 24'h0));
        directed.push_back(mk_frag(OP_READ_COLOR, 0, 0, 32'h0, 24'h0));
        directed.push_back(mk_frag(OP_READ_DEPTH, 255, 255, 32'h0, 24'h0));

        src_idle_pct   = 10;
        sink_stall_pct = 4;
        foreach (directed[i])
            drive_fragment(directed[i]);
        drain_results();

        // Random phases; the last one runs without idling on either side
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 0)
                clr = 32'hFFFFFFFF;
            else if (p == 5)
                clr = 32'h00000000;
            else
                clr = $urandom;
            load_frame_regs(PHASE_W[p], PHASE_H[p], clr);
            eff_w = (PHASE_W[p] > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : PHASE_W[p];
            eff_h = (PHASE_H[p] > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : PHASE_H[p];

            if (p == NUM_PHASES - 1)
            begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: src_idle_pct = 0;
                    1: src_idle_pct = 10;
                    default: src_idle_pct = 30;
                endcase
                case ($urandom_range(0, 2))
                    0: sink_stall_pct = 0;
                    1: sink_stall_pct = 4;
                    default: sink_stall_pct = 12;
                endcase
            end

            depth_front = 24'hC00000;
            for (int i = 0; i < PHASE_ITEMS[p]; i++)
                drive_fragment(random_fragment(eff_w, eff_h, i == PHASE_ITEMS[p] - 1));
            // a sender pause until every result is back
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
